@@ design/psg_pkg.sv @@
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, codes and constant tables for the sound generator register
// file and noise channel.
// ----------------------------------------------------------------------------
package psg_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_SILENCE = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    localparam int unsigned PeriodWidth = 10;
    localparam int unsigned AttenWidth  = 4;
    localparam int unsigned ShiftWidth  = 16;
    localparam int unsigned RateWidth   = 11;
    localparam logic [AttenWidth-1:0] AttenSilent = 4'hF;
    localparam logic [15:0] CpsReset = 16'd81;

    // Noise control request from the register decode to the noise channel
    typedef struct packed {
        logic       tick;
        logic       load;
        logic [2:0] ctrl;
    } noise_ctl_t;

    function automatic logic [15:0] level_lookup(input logic [3:0] code);
        logic [15:0] lvl;
        unique case (code)
            4'd0:  lvl = 16'h7FFF;
            4'd1:  lvl = 16'h65AC;
            4'd2:  lvl = 16'h50C3;
            4'd3:  lvl = 16'h4026;
            4'd4:  lvl = 16'h32F5;
            4'd5:  lvl = 16'h287A;
            4'd6:  lvl = 16'h2027;
            4'd7:  lvl = 16'h19A8;
            4'd8:  lvl = 16'h1449;
            4'd9:  lvl = 16'h101D;
            4'd10: lvl = 16'h0CCD;
            4'd11: lvl = 16'h0A2B;
            4'd12: lvl = 16'h0813;
            4'd13: lvl = 16'h066A;
            4'd14: lvl = 16'h0518;
            default: lvl = 16'h0000;
        endcase
        return lvl;
    endfunction

    function automatic logic [ShiftWidth-1:0] seed_lookup(input logic [1:0] code);
        logic [ShiftWidth-1:0] s;
        unique case (code)
            2'd0:    s = 16'h0010;
            2'd1:    s = 16'h0020;
            2'd2:    s = 16'h0040;
            default: s = 16'h0000;
        endcase
        return s;
    endfunction

    function automatic logic [RateWidth-1:0] rate_lookup(input logic [1:0] code);
        logic [RateWidth-1:0] r;
        unique case (code)
            2'd0:    r = 11'h100;
            2'd1:    r = 11'h200;
            2'd2:    r = 11'h400;
            default: r = 11'h000;
        endcase
        return r;
    endfunction

endpackage

@@ design/psg_regfile.sv @@
// ----------------------------------------------------------------------------
// psg_regfile
// Byte decode, tone periods, attenuations and latch select; issues noise
// control requests.
// ----------------------------------------------------------------------------
module psg_regfile (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    enable,
    input  psg_pkg::mode_t                          mode,
    input  logic [7:0]                              data,
    output psg_pkg::noise_ctl_t                     noise_ctl,
    output logic [psg_pkg::PeriodWidth-1:0]         period [3],
    output logic [psg_pkg::AttenWidth-1:0]          atten [4],
    output logic [psg_pkg::AttenWidth-1:0]          noise_atten_next
);

    logic [psg_pkg::PeriodWidth-1:0] period_reg [3];
    logic [psg_pkg::PeriodWidth-1:0] period_next [3];
    logic [psg_pkg::AttenWidth-1:0]  atten_reg [4];
    logic [psg_pkg::AttenWidth-1:0]  atten_next [4];
    logic [2:0]                      latch_reg;
    logic [2:0]                      latch_next;
    logic [2:0]                      sel;
    logic [1:0]                      chan;

    always_comb
    begin
        period_next = period_reg;
        atten_next  = atten_reg;
        latch_next  = latch_reg;
        noise_ctl   = '0;
        sel  = data[7] ? data[6:4] : latch_reg;
        chan = sel[2:1];
        noise_ctl.ctrl = data[2:0];
        unique case (mode)
            psg_pkg::MODE_WRITE:
            begin
                latch_next = sel;
                if (sel[0])
                begin
                    atten_next[chan] = data[3:0];
                end
                else if (chan == 2'd3)
                begin
                    noise_ctl.load = 1'b1;
                end
                else if (data[7])
                begin
                    period_next[chan] = {6'd0, data[3:0]};
                end
                else
                begin
                    period_next[chan] = {data[5:0], period_reg[chan][3:0]};
                end
            end
            psg_pkg::MODE_TICK:
            begin
                noise_ctl.tick = 1'b1;
            end
            psg_pkg::MODE_SILENCE:
            begin
                atten_next[0] = psg_pkg::AttenSilent;
                atten_next[1] = psg_pkg::AttenSilent;
                atten_next[2] = psg_pkg::AttenSilent;
            end
            default:
            begin
            end
        endcase
        if (!enable)
        begin
            noise_ctl = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '{default: '0};
            atten_reg  <= '{default: psg_pkg::AttenSilent};
            latch_reg  <= '0;
        end
        else if (enable)
        begin
            period_reg <= period_next;
            atten_reg  <= atten_next;
            latch_reg  <= latch_next;
        end
    end

    assign period = period_reg;
    assign atten  = atten_reg;
    // hold the current code when no item is processed
    assign noise_atten_next = enable ? atten_next[3] : atten_reg[3];

endmodule

@@ design/psg_noise.sv @@
// ----------------------------------------------------------------------------
// psg_lfsr_chan
// Noise channel: fractional divider, rate and 16-bit shift register.
// ----------------------------------------------------------------------------
module psg_lfsr_chan (
    input  logic                rst_n,
    input  logic                clk,
    input  psg_pkg::noise_ctl_t noise_ctl,
    input  logic [15:0]         clocks_per_sample,
    output logic                noise_bit,
    output logic                noise_bit_next
);

    logic [psg_pkg::ShiftWidth-1:0] shift_reg, shift_next;
    logic [15:0]                    div_reg, div_next;
    logic [psg_pkg::RateWidth-1:0]  rate_reg, rate_next;
    logic                           white_reg, white_next;
    logic [15:0]                    div_sum;
    logic [15:0]                    rate_ext;
    logic                           fb;

    always_comb
    begin
        shift_next = shift_reg;
        div_next   = div_reg;
        rate_next  = rate_reg;
        white_next = white_reg;
        rate_ext   = {5'd0, rate_reg};
        div_sum    = div_reg + clocks_per_sample;
        fb         = white_reg ? (shift_reg[0] ^ shift_reg[3]) : shift_reg[0];
        priority if (noise_ctl.load)
        begin
            shift_next = psg_pkg::seed_lookup(noise_ctl.ctrl[1:0]);
            rate_next  = psg_pkg::rate_lookup(noise_ctl.ctrl[1:0]);
            white_next = noise_ctl.ctrl[2];
            div_next   = '0;
        end
        else if (noise_ctl.tick)
        begin
            div_next = div_sum;
            if (div_sum > rate_ext)
            begin
                // advance the register once per rate period
                div_next   = div_sum - rate_ext;
                shift_next = {fb, shift_reg[psg_pkg::ShiftWidth-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 16'h0001;
            div_reg   <= '0;
            rate_reg  <= '0;
            white_reg <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            div_reg   <= div_next;
            rate_reg  <= rate_next;
            white_reg <= white_next;
        end
    end

    assign noise_bit      = shift_reg[0];
    assign noise_bit_next = shift_next[0];

endmodule

@@ design/psg_registers_and_noise_channel.sv @@
// ----------------------------------------------------------------------------
// psg_registers_and_noise_channel
// Register interface and noise channel of a four-voice sound generator.
// ----------------------------------------------------------------------------
// One item per clock cycle while the result side does not stall: an accepted
// item is captured in an input register, then decoded and applied to the
// register file and noise channel as its result item is registered.
// A result item reports the state after its item: the tone periods, the four
// attenuation codes, bit 0 of the noise shift register and the signed noise
// level (plus or minus the attenuation level, full scale 0x7FFF). Write
// clocks_per_sample only while no item is in flight; reset value is 81.
// ----------------------------------------------------------------------------
module psg_registers_and_noise_channel (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    // input items
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [7:0]          data,
    // result items
    output logic                out_valid,
    input  logic                out_stall,
    output logic                noise_bit,
    output logic signed [15:0]  noise_level,
    output logic [9:0]          tone0_period,
    output logic [9:0]          tone1_period,
    output logic [9:0]          tone2_period,
    output logic [3:0]          tone0_atten,
    output logic [3:0]          tone1_atten,
    output logic [3:0]          tone2_atten,
    output logic [3:0]          noise_atten
);

    logic [15:0]          cps_reg;
    logic                 in_valid_reg;
    psg_pkg::mode_t       mode_reg;
    logic [7:0]           data_reg;
    logic                 out_valid_reg;
    logic [15:0]          level_reg, level_next;
    logic                 advance;
    logic                 process;
    psg_pkg::noise_ctl_t  noise_ctl;
    logic [psg_pkg::PeriodWidth-1:0] period [3];
    logic [psg_pkg::AttenWidth-1:0]  atten [4];
    logic [psg_pkg::AttenWidth-1:0]  noise_atten_next;
    logic                 bit_next;
    logic [15:0]          lvl;

    // The result register moves whenever it is empty or being taken;
    // the item in the input register is processed on that same edge.
    assign advance  = !out_valid_reg || !out_stall;
    assign process  = advance && in_valid_reg;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg <= psg_pkg::CpsReset;
        end
        else if (cfg_wr_en)
        begin
            cps_reg <= cfg_wr_data;
        end
    end

    // Input register: load a new item whenever this stage is not held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            mode_reg <= psg_pkg::mode_t'(mode);
            data_reg <= data;
        end
    end

    psg_regfile u_regfile (
        .clk              (clk),
        .rst_n            (rst_n),
        .enable           (process),
        .mode             (mode_reg),
        .data             (data_reg),
        .noise_ctl        (noise_ctl),
        .period           (period),
        .atten            (atten),
        .noise_atten_next (noise_atten_next)
    );

    psg_lfsr_chan u_noise (
        .rst_n             (rst_n),
        .clk               (clk),
        .noise_ctl         (noise_ctl),
        .clocks_per_sample (cps_reg),
        .noise_bit         (noise_bit),
        .noise_bit_next    (bit_next)
    );

    // Signed level from the post-update attenuation and noise bit.
    always_comb
    begin
        lvl        = psg_pkg::level_lookup(noise_atten_next);
        level_next = bit_next ? lvl : 16'(16'd0 - lvl);
    end

    // Result register: the state registers themselves carry the register
    // fields; the level is captured alongside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            level_reg <= level_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign noise_level  = level_reg;
    assign tone0_period = period[0];
    assign tone1_period = period[1];
    assign tone2_period = period[2];
    assign tone0_atten  = atten[0];
    assign tone1_atten  = atten[1];
    assign tone2_atten  = atten[2];
    assign noise_atten  = atten[3];

    // A stalled result holds its noise fields.
    a_hold_noise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(noise_bit) && $stable(noise_level))
        else $error("noise result changed under stall");

    // Nonzero level carries the sign given by the noise bit.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && noise_level != 16'sd0 |-> noise_bit == !noise_level[15])
        else $error("noise level sign does not match noise bit");

    // Silent code gives a zero level.
    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && noise_atten == psg_pkg::AttenSilent |-> noise_level == 16'sd0)
        else $error("silent noise code with nonzero level");

    // Input side holds only while a result waits.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input held without a waiting result");

endmodule

@@ sim/psg_registers_and_noise_channel_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_registers_and_noise_channel_tb
// Drives register writes, sample ticks and silence requests into the sound
// generator register file and noise channel, and checks every result item
// against a cycle-free copy of the register and shift register behavior.
// The run is a short directed pass followed by random phases, each with its
// own clocks_per_sample setting.
// ----------------------------------------------------------------------------
module psg_registers_and_noise_channel_tb;

    localparam int unsigned PhaseItems    = 160;
    localparam int unsigned IdleLimit     = 4000;
    localparam int unsigned HoldOffAt     = 300;
    localparam int unsigned HoldOffCycles = 80;
    localparam int unsigned CalmFrom      = 500;
    localparam int unsigned CalmTo        = 700;
    localparam int unsigned SettleCycles  = 8;

    // Output level per attenuation code, code 0 at the low end
    localparam logic [15:0][15:0] LevelByCode = {
        16'h0000, 16'h0518, 16'h066A, 16'h0813, 16'h0A2B, 16'h0CCD, 16'h101D, 16'h1449,
        16'h19A8, 16'h2027, 16'h287A, 16'h32F5, 16'h4026, 16'h50C3, 16'h65AC, 16'h7FFF
    };

    // Everything one result item carries
    typedef struct packed {
        logic        noise_bit;
        logic [15:0] noise_level;
        logic [9:0]  period0;
        logic [9:0]  period1;
        logic [9:0]  period2;
        logic [3:0]  atten0;
        logic [3:0]  atten1;
        logic [3:0]  atten2;
        logic [3:0]  atten3;
    } psg_snapshot_t;

    // One directed item; pinned rows carry a hand-written snapshot
    typedef struct {
        psg_pkg::mode_t m;
        logic [7:0]     d;
        logic           pinned;
        psg_snapshot_t  want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [15:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    psg_pkg::mode_t     mode;
    logic [7:0]         data;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               noise_bit;
    logic signed [15:0] noise_level;
    logic [9:0]         tone0_period;
    logic [9:0]         tone1_period;
    logic [9:0]         tone2_period;
    logic [3:0]         tone0_atten;
    logic [3:0]         tone1_atten;
    logic [3:0]         tone2_atten;
    logic [3:0]         noise_atten;

    // Register file and noise channel as the checker sees them
    logic [15:0] cps;
    logic [9:0]  tone_period [3];
    logic [3:0]  atten_code [4];
    logic [2:0]  latch_field;
    logic [15:0] lfsr;
    logic [15:0] divider;
    logic [10:0] rate_limit;
    logic        white;

    psg_snapshot_t snapshots_due [$];
    stim_row_t     directed_rows [$];

    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned failures      = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;

    psg_registers_and_noise_channel dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .data         (data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .noise_bit    (noise_bit),
        .noise_level  (noise_level),
        .tone0_period (tone0_period),
        .tone1_period (tone1_period),
        .tone2_period (tone2_period),
        .tone0_atten  (tone0_atten),
        .tone1_atten  (tone1_atten),
        .tone2_atten  (tone2_atten),
        .noise_atten  (noise_atten)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one item to the checker's copy of the block and return the
    // snapshot that the block must report for it.
    function automatic psg_snapshot_t psg_advance(
        input psg_pkg::mode_t m, input logic [7:0] d
    );
        psg_snapshot_t s;
        logic [1:0]    sel;
        logic [1:0]    code;
        logic          feedback;
        logic [15:0]   lvl;
        case (m)
            psg_pkg::MODE_WRITE:
            begin
                // A latch byte picks the register; a data byte reuses the pick
                if (d[7])
                    latch_field = d[6:4];
                sel = latch_field[2:1];
                if (latch_field[0])
                    atten_code[sel] = d[3:0];
                else if (sel == 2'd3)
                begin
                    // Noise control: reseed, pick the rate, clear the divider
                    code       = d[1:0];
                    lfsr       = (code == 2'd3) ? 16'h0000 : 16'h0010 << code;
                    rate_limit = (code == 2'd3) ? 11'h000 : 11'h100 << code;
                    white      = d[2];
                    divider    = '0;
                end
                else if (d[7])
                    tone_period[sel] = {6'd0, d[3:0]};
                else
                    tone_period[sel] = {d[5:0], tone_period[sel][3:0]};
            end
            psg_pkg::MODE_TICK:
            begin
                // Wrap at 16 bits, then shift once when the divider passes the rate
                divider = divider + cps;
                if (divider > {5'd0, rate_limit})
                begin
                    divider  = divider - {5'd0, rate_limit};
                    feedback = white ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
                    lfsr     = {feedback, lfsr[15:1]};
                end
            end
            psg_pkg::MODE_SILENCE:
            begin
                atten_code[0] = psg_pkg::AttenSilent;
                atten_code[1] = psg_pkg::AttenSilent;
                atten_code[2] = psg_pkg::AttenSilent;
            end
            default:
            begin
            end
        endcase
        lvl           = LevelByCode[atten_code[3]];
        s.noise_bit   = lfsr[0];
        s.noise_level = lfsr[0] ? lvl : 16'd0 - lvl;
        s.period0     = tone_period[0];
        s.period1     = tone_period[1];
        s.period2     = tone_period[2];
        s.atten0      = atten_code[0];
        s.atten1      = atten_code[1];
        s.atten2      = atten_code[2];
        s.atten3      = atten_code[3];
        return s;
    endfunction

    function automatic psg_snapshot_t snap(
        input logic nb, input logic [15:0] lvl,
        input logic [9:0] p0, input logic [9:0] p1, input logic [9:0] p2,
        input logic [3:0] a0, input logic [3:0] a1, input logic [3:0] a2, input logic [3:0] a3
    );
        psg_snapshot_t s;
        s.noise_bit   = nb;
        s.noise_level = lvl;
        s.period0     = p0;
        s.period1     = p1;
        s.period2     = p2;
        s.atten0      = a0;
        s.atten1      = a1;
        s.atten2      = a2;
        s.atten3      = a3;
        return s;
    endfunction

    function automatic stim_row_t row(
        input psg_pkg::mode_t m, input logic [7:0] d, input logic pinned,
        input psg_snapshot_t want
    );
        stim_row_t r;
        r.m      = m;
        r.d      = d;
        r.pinned = pinned;
        r.want   = want;
        return r;
    endfunction

    // Offer one item, hold it until accepted, then queue its snapshot.
    task automatic send_item(
        input psg_pkg::mode_t m, input logic [7:0] d, input logic pinned,
        input psg_snapshot_t want
    );
        psg_snapshot_t predicted;
        // Drop valid for a random gap, except inside the calm stretch
        while (!(items_sent >= CalmFrom && items_sent < CalmTo) && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        data     <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        predicted = psg_advance(m, d);
        snapshots_due.push_back(pinned ? want : predicted);
    endtask

    task automatic send_free(input psg_pkg::mode_t m, input logic [7:0] d);
        send_item(m, d, 1'b0, '0);
    endtask

    // One random burst: mostly well-formed latch/data pairs and tick runs,
    // with lone latch and data bytes, silence and the unused mode mixed in.
    task automatic send_random_burst(output int unsigned count);
        int unsigned pick;
        int unsigned n;
        pick  = $urandom_range(0, 99);
        count = 1;
        if (pick < 35)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_free(psg_pkg::MODE_TICK, 8'($urandom));
            count = n;
        end
        else if (pick < 60)
        begin
            send_free(psg_pkg::MODE_WRITE, {1'b1, 7'($urandom)});
            send_free(psg_pkg::MODE_WRITE, {1'b0, 7'($urandom)});
            count = 2;
        end
        else if (pick < 72)
            send_free(psg_pkg::MODE_WRITE, {4'hE, 4'($urandom)});
        else if (pick < 82)
            send_free(psg_pkg::MODE_WRITE, {1'b1, 2'($urandom), 1'b1, 4'($urandom)});
        else if (pick < 88)
            send_free(psg_pkg::MODE_WRITE, {1'b0, 7'($urandom)});
        else if (pick < 93)
            send_free(psg_pkg::MODE_SILENCE, 8'($urandom));
        else if (pick < 97)
            send_free(psg_pkg::MODE_UNUSED, 8'($urandom));
        else
            send_free(psg_pkg::MODE_WRITE, {1'b1, 7'($urandom)});
    endtask

    // Drain the block, let the pipeline settle, then write the register.
    task automatic set_clocks_per_sample(input logic [15:0] value);
        in_valid <= 1'b0;
        while (snapshots_due.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cps = value;
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    task automatic check_snapshot();
        psg_snapshot_t want;
        if (snapshots_due.size() == 0)
        begin
            $error("result item arrived with no item pending");
            failures++;
        end
        else
        begin
            want = snapshots_due.pop_front();
            check_field("noise_bit", 16'(want.noise_bit), 16'(noise_bit));
            check_field("noise_level", want.noise_level, noise_level);
            check_field("tone0_period", 16'(want.period0), 16'(tone0_period));
            check_field("tone1_period", 16'(want.period1), 16'(tone1_period));
            check_field("tone2_period", 16'(want.period2), 16'(tone2_period));
            check_field("tone0_atten", 16'(want.atten0), 16'(tone0_atten));
            check_field("tone1_atten", 16'(want.atten1), 16'(tone1_atten));
            check_field("tone2_atten", 16'(want.atten2), 16'(tone2_atten));
            check_field("noise_atten", 16'(want.atten3), 16'(noise_atten));
        end
    endtask

    // Result side: check accepted items, then pick the next stall. One long
    // hold-off lets the block fill up and push back on the sender; a calm
    // stretch runs with no stalls at all.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            check_snapshot();
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HoldOffAt)
        begin
            hold_done = 1'b1;
            hold_left = HoldOffCycles - 1;
            out_stall <= 1'b1;
        end
        else if (results_seen >= CalmFrom && results_seen < CalmTo)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 8);
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IdleLimit)
        begin
            $display("psg_registers_and_noise_channel_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] rate_plan [7];
        int unsigned sent;
        int unsigned burst;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= psg_pkg::MODE_WRITE;
        data        <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= psg_pkg::CpsReset;

        // Reset state of the checker's copy
        cps         = psg_pkg::CpsReset;
        tone_period = '{default: '0};
        atten_code  = '{default: psg_pkg::AttenSilent};
        latch_field = '0;
        lfsr        = 16'h0001;
        divider     = '0;
        rate_limit  = '0;
        white       = 1'b0;

        // Directed pass at the reset rate. Pinned snapshots: state right
        // after reset, full-scale noise level, full tone period, and the
        // zero-rate tick with an all-zero shift register (negative full scale).
        directed_rows.push_back(row(psg_pkg::MODE_SILENCE, 8'h00, 1'b1,
            snap(1'b1, 16'h0000, 10'h000, 10'h000, 10'h000, 4'hF, 4'hF, 4'hF, 4'hF)));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hF0, 1'b1,
            snap(1'b1, 16'h7FFF, 10'h000, 10'h000, 10'h000, 4'hF, 4'hF, 4'hF, 4'h0)));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h8F, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h3F, 1'b1,
            snap(1'b1, 16'h7FFF, 10'h3FF, 10'h000, 10'h000, 4'hF, 4'hF, 4'hF, 4'h0)));
        // latch byte on a tone period clears its high bits
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h81, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hA5, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h7F, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hCA, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h40, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h90, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hBF, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hD7, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h05, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hFE, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h0F, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hF0, 1'b0, '0));
        // white noise at the fastest seeded rate, then enough ticks to shift
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hE4, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_TICK, 8'h00, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_TICK, 8'hFF, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_TICK, 8'h00, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_TICK, 8'hFF, 1'b0, '0));
        // rate code 3: zero seed, zero rate
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'hE3, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_TICK, 8'h00, 1'b1,
            snap(1'b0, 16'h8001, 10'h001, 10'h3F5, 10'h00A, 4'h0, 4'hF, 4'h5, 4'h0)));
        // noise control through a data byte, unused mode, silence
        directed_rows.push_back(row(psg_pkg::MODE_WRITE, 8'h06, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_UNUSED, 8'hFF, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_SILENCE, 8'hFF, 1'b0, '0));
        directed_rows.push_back(row(psg_pkg::MODE_TICK, 8'h00, 1'b0, '0));

        // Rates for the random phases: both extremes, tiny, mid, random and the reset value
        rate_plan[0] = 16'd0;
        rate_plan[1] = 16'hFFFF;
        rate_plan[2] = 16'd1;
        rate_plan[3] = 16'd255;
        rate_plan[4] = 16'($urandom_range(0, 2000));
        rate_plan[5] = 16'($urandom);
        rate_plan[6] = psg_pkg::CpsReset;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].m, directed_rows[i].d,
                      directed_rows[i].pinned, directed_rows[i].want);

        foreach (rate_plan[p])
        begin
            set_clocks_per_sample(rate_plan[p]);
            sent = 0;
            while (sent < PhaseItems)
            begin
                send_random_burst(burst);
                sent += burst;
            end
        end

        // Drain, then give the pipeline time to show any stray result
        in_valid <= 1'b0;
        while (snapshots_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles)
            @(posedge clk);

        if (failures == 0)
            $display("psg_registers_and_noise_channel_tb OK");
        else
            $display("psg_registers_and_noise_channel_tb NOT OK");
        $finish;
    end

endmodule
